@@ rtl/core/pitot_airspeed_frame_processor_unit_assert.svh @@
// Assertion macros shared by the airspeed frame processor RTL.
`ifndef PITOT_AIRSPEED_FRAME_PROCESSOR_UNIT_ASSERT_SVH
`define PITOT_AIRSPEED_FRAME_PROCESSOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define PAFP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("airspeed frame processor: implication check failed");

// Next-cycle implication, disabled while reset is applied.
`define PAFP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("airspeed frame processor: next-cycle check failed");

`endif

@@ rtl/core/pafp_pkg.sv @@
// Package with the types and constants of the airspeed frame processor.
`default_nettype none

package pafp_pkg;

    localparam int PRESS_FRAC_DEFAULT = 4;
    localparam int SPEED_FRAC_DEFAULT = 8;

    localparam int DIVISOR_W = 24;
    localparam int FILT_W    = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILT_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_DENSITY = 2'd3;

    localparam logic [10:0] CAL_SAMPLES_RST = 11'd100;
    localparam logic [16:0] FILT_ALPHA_RST  = 17'd6554;
    localparam logic [13:0] DEADBAND_RST    = 14'd0;
    localparam logic [10:0] AIR_DENSITY_RST = 11'd1225;

    localparam logic [1:0] STATUS_NORMAL = 2'd0;

    localparam int TEMP_SCALE  = 102400;
    localparam int TEMP_HALF   = 2047;
    localparam int TEMP_DIV    = 4094;
    localparam int TEMP_OFFSET = 12800;

    localparam int PRESS_MID   = 16383;
    localparam int PRESS_SCALE = 6894757;
    localparam int PRESS_DIV   = 13106400;
    localparam int PRESS_HALF  = 6553200;
    localparam int PRESS_LIMIT = 262143;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam int FILT_HALF   = 32768;
    localparam int SPEED_SCALE = 8000;
    localparam int SPEED_MAX   = 65535;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEMP,
        ST_TEMP_WAIT,
        ST_PRESS_WAIT,
        ST_CAL,
        ST_CAL_CHECK,
        ST_ZERO_WAIT,
        ST_CORR,
        ST_FMUL,
        ST_FADD,
        ST_SPEED,
        ST_SPD_DIV,
        ST_SPD_WAIT,
        ST_SQRT_WAIT,
        ST_DONE
    } pafp_state_t;

endpackage

`default_nettype wire

@@ rtl/core/pafp_div.sv @@
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module pafp_div #(
    parameter int DIV_W = 47,
    parameter int DVS_W = pafp_pkg::DIVISOR_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/pafp_sqrt.sv @@
// Digit-serial integer square root, one root bit per cycle.
`default_nettype none

module pafp_sqrt #(
    parameter int SQ_W = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [SQ_W/2-1:0] root
);

    localparam int RW    = SQ_W / 2;
    localparam int CNT_W = $clog2(RW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]  x_reg, x_next;
    logic [RW+1:0]    rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [RW+3:0]    part;
    logic [RW+3:0]    trial;
    logic [RW+3:0]    diff;
    logic             ge;

    always_comb
    begin
        part      = {rem_reg, x_reg[SQ_W-1:SQ_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = part - trial;
        ge        = part >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (busy_reg)
        begin
            x_next    = {x_reg[SQ_W-3:0], 2'b00};
            rem_next  = ge ? diff[RW+1:0] : part[RW+1:0];
            root_next = {root_reg[RW-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ rtl/core/pitot_airspeed_frame_processor_unit.sv @@
// Top level of the differential-pressure airspeed frame processor.
`default_nettype none

// One sensor word is processed at a time. A rejected word goes from ST_IDLE to ST_DONE
// and is then loaded into the output register. A calibrating word uses the temperature
// and pressure divisions, and the word that completes calibration also the zero offset
// division. A calibrated word uses the temperature, pressure and airspeed divisions and
// the square root; the word that seeds the filter skips the filter update. DIV_W is
// max(31 + 2*SPEED_FRAC_BITS, 39 + PRESSURE_FRAC_BITS) and SQ_W is DIV_W rounded up
// to an even number. One shared bit-serial divider does the temperature, pressure,
// zero offset and airspeed divisions in turn, followed by the bit-serial square root.
// A finished result waits in the output register while the next word is taken in; a
// result that finds that register still full holds the block until it is taken.

module pitot_airspeed_frame_processor_unit #(
    parameter int PRESSURE_FRAC_BITS = pafp_pkg::PRESS_FRAC_DEFAULT,
    parameter int SPEED_FRAC_BITS    = pafp_pkg::SPEED_FRAC_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    frame_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     sensor_status,
    output logic                           accepted,
    output logic                           airspeed_valid,
    output logic [13:0]                    raw_pressure,
    output logic [10:0]                    raw_temperature,
    output logic signed [16:0]             temperature,
    output logic signed [18:0]             filtered_pressure,
    output logic [15:0]                    airspeed,
    input  logic                           wr_en,
    input  logic [pafp_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pafp_pkg::CFG_DAT_W-1:0] wr_data
);

    import pafp_pkg::*;
    `include "pitot_airspeed_frame_processor_unit_assert.svh"

    localparam int PRESS_W = 15 + PRESSURE_FRAC_BITS;
    localparam int SUM_W   = PRESS_W + 11;
    localparam int CW      = (PRESS_W + 1 > 20) ? PRESS_W + 1 : 20;
    localparam int SPD_NW  = 31 + 2 * SPEED_FRAC_BITS;
    localparam int PRS_NW  = 39 + PRESSURE_FRAC_BITS;
    localparam int DIV_W   = (SPD_NW > PRS_NW) ? SPD_NW : PRS_NW;
    localparam int SQ_W    = DIV_W + (DIV_W % 2);
    localparam int RW      = SQ_W / 2;

    localparam logic signed [CW-1:0] C_LIM = CW'(PRESS_LIMIT);
    localparam logic signed [21:0]   F_LIM = 22'(PRESS_LIMIT);

    pafp_state_t state_reg, state_next;

    logic [10:0] cfg_samples_reg, cfg_samples_next;
    logic [16:0] cfg_alpha_reg, cfg_alpha_next;
    logic [13:0] cfg_db_reg, cfg_db_next;
    logic [10:0] cfg_dens_reg, cfg_dens_next;

    logic                      cal_reg, cal_next;
    logic [10:0]               count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [PRESS_W-1:0] zero_reg, zero_next;
    logic                      seeded_reg, seeded_next;
    logic signed [FILT_W-1:0]  filt_reg, filt_next;

    logic [1:0]                status_reg, status_next;
    logic [13:0]               rawp_reg, rawp_next;
    logic [10:0]               rawt_reg, rawt_next;
    logic                      acc_reg, acc_next;
    logic                      asv_reg, asv_next;
    logic signed [16:0]        temp_reg, temp_next;
    logic [37:0]               pmul_reg, pmul_next;
    logic                      pneg_reg, pneg_next;
    logic signed [PRESS_W-1:0] press_reg, press_next;
    logic signed [FILT_W-1:0]  corr_reg, corr_next;
    logic [35:0]               fprod_reg, fprod_next;
    logic                      fneg_reg, fneg_next;
    logic [30:0]               qmul_reg, qmul_next;
    logic [15:0]               speed_reg, speed_next;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                o_status_reg, o_status_next;
    logic                      o_acc_reg, o_acc_next;
    logic                      o_asv_reg, o_asv_next;
    logic [13:0]               o_rawp_reg, o_rawp_next;
    logic [10:0]               o_rawt_reg, o_rawt_next;
    logic signed [16:0]        o_temp_reg, o_temp_next;
    logic signed [18:0]        o_filt_reg, o_filt_next;
    logic [15:0]               o_speed_reg, o_speed_next;

    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_dividend, div_quo;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 sqrt_start, sqrt_done;
    logic [RW-1:0]        sq_root;

    logic [27:0]               tnum;
    logic [15:0]               pdiff;
    logic [14:0]               pmag;
    logic signed [PRESS_W-1:0] dq_press;
    logic [SUM_W-1:0]          sum_mag;
    logic signed [CW-1:0]      cdiff;
    logic signed [19:0]        dlt;
    logic [18:0]               dmag;
    logic [16:0]               alpha_eff;
    logic [35:0]               rnd_w;
    logic [19:0]               rnd;
    logic signed [21:0]        fsum;
    logic signed [19:0]        sdiff;
    logic [17:0]               qval;
    logic [10:0]               dens_eff;
    logic [RW:0]               rt1;
    logic [RW-1:0]             vhalf;
    logic                      in_div_wait;
    logic                      out_rejected;

    always_comb
    begin
        tnum      = 28'(rawt_reg) * 28'(TEMP_SCALE) + 28'(TEMP_HALF);
        pdiff     = {1'b0, rawp_reg, 1'b0} - 16'(PRESS_MID);
        pmag      = pdiff[15] ? 15'(-pdiff) : pdiff[14:0];
        dq_press  = signed'(PRESS_W'(div_quo));
        sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        cdiff     = CW'(press_reg) - CW'(zero_reg);
        dlt       = 20'(corr_reg) - 20'(filt_reg);
        dmag      = dlt[19] ? 19'(-dlt) : dlt[18:0];
        alpha_eff = (cfg_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha_reg;
        rnd_w     = fprod_reg + 36'(FILT_HALF);
        rnd       = rnd_w[35:16];
        fsum      = fneg_reg ? (22'(filt_reg) - signed'(22'(rnd)))
                             : (22'(filt_reg) + signed'(22'(rnd)));
        sdiff     = 20'(filt_reg) - signed'(20'(cfg_db_reg));
        qval      = (sdiff > 20'sd0) ? sdiff[17:0] : 18'd0;
        dens_eff  = (cfg_dens_reg == 11'd0) ? 11'd1 : cfg_dens_reg;
        rt1       = {1'b0, sq_root} + 1'b1;
        vhalf     = rt1[RW:1];
    end

    always_comb
    begin
        state_next       = state_reg;
        cfg_samples_next = cfg_samples_reg;
        cfg_alpha_next   = cfg_alpha_reg;
        cfg_db_next      = cfg_db_reg;
        cfg_dens_next    = cfg_dens_reg;
        cal_next         = cal_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        zero_next        = zero_reg;
        seeded_next      = seeded_reg;
        filt_next        = filt_reg;
        status_next      = status_reg;
        rawp_next        = rawp_reg;
        rawt_next        = rawt_reg;
        acc_next         = acc_reg;
        asv_next         = asv_reg;
        temp_next        = temp_reg;
        pmul_next        = pmul_reg;
        pneg_next        = pneg_reg;
        press_next       = press_reg;
        corr_next        = corr_reg;
        fprod_next       = fprod_reg;
        fneg_next        = fneg_reg;
        qmul_next        = qmul_reg;
        speed_next       = speed_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        o_status_next    = o_status_reg;
        o_acc_next       = o_acc_reg;
        o_asv_next       = o_asv_reg;
        o_rawp_next      = o_rawp_reg;
        o_rawt_next      = o_rawt_reg;
        o_temp_next      = o_temp_reg;
        o_filt_next      = o_filt_reg;
        o_speed_next     = o_speed_reg;
        div_start        = 1'b0;
        div_dividend     = '0;
        div_divisor      = '0;
        sqrt_start       = 1'b0;

        if (wr_en)
        begin
            unique case (wr_index)
                REG_CAL_SAMPLES: cfg_samples_next = wr_data[10:0];
                REG_FILT_ALPHA:  cfg_alpha_next   = wr_data;
                REG_DEADBAND:    cfg_db_next      = wr_data[13:0];
                REG_AIR_DENSITY: cfg_dens_next    = wr_data[10:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = frame_word[31:30];
                    rawp_next   = frame_word[29:16];
                    rawt_next   = frame_word[15:5];
                    acc_next    = frame_word[31:30] == STATUS_NORMAL;
                    asv_next    = 1'b0;
                    state_next  = (frame_word[31:30] == STATUS_NORMAL) ? ST_TEMP : ST_DONE;
                end
            end
            ST_TEMP:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(tnum);
                div_divisor  = DIVISOR_W'(TEMP_DIV);
                pmul_next    = 38'(pmag) * 38'(PRESS_SCALE);
                pneg_next    = pdiff[15];
                state_next   = ST_TEMP_WAIT;
            end
            ST_TEMP_WAIT:
            begin
                if (div_done)
                begin
                    temp_next    = signed'(17'(div_quo[15:0])) - 17'(TEMP_OFFSET);
                    div_start    = 1'b1;
                    div_dividend = (DIV_W'(pmul_reg) << PRESSURE_FRAC_BITS)
                                   + DIV_W'(PRESS_HALF);
                    div_divisor  = DIVISOR_W'(PRESS_DIV);
                    state_next   = ST_PRESS_WAIT;
                end
            end
            ST_PRESS_WAIT:
            begin
                if (div_done)
                begin
                    press_next = pneg_reg ? -dq_press : dq_press;
                    state_next = cal_reg ? ST_CORR : ST_CAL;
                end
            end
            ST_CAL:
            begin
                sum_next   = sum_reg + SUM_W'(press_reg);
                count_next = count_reg + 11'd1;
                state_next = ST_CAL_CHECK;
            end
            ST_CAL_CHECK:
            begin
                if (count_reg >= cfg_samples_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(sum_mag) + DIV_W'(count_reg >> 1);
                    div_divisor  = DIVISOR_W'(count_reg);
                    state_next   = ST_ZERO_WAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ZERO_WAIT:
            begin
                if (div_done)
                begin
                    zero_next  = sum_reg[SUM_W-1] ? -dq_press : dq_press;
                    cal_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_CORR:
            begin
                if (cdiff > C_LIM)
                begin
                    corr_next = FILT_W'(PRESS_LIMIT);
                end
                else if (cdiff < -C_LIM)
                begin
                    corr_next = -FILT_W'(PRESS_LIMIT);
                end
                else
                begin
                    corr_next = FILT_W'(cdiff);
                end
                state_next = ST_FMUL;
            end
            ST_FMUL:
            begin
                if (!seeded_reg)
                begin
                    filt_next   = corr_reg;
                    seeded_next = 1'b1;
                    state_next  = ST_SPEED;
                end
                else
                begin
                    fprod_next = 36'(dmag) * 36'(alpha_eff);
                    fneg_next  = dlt[19];
                    state_next = ST_FADD;
                end
            end
            ST_FADD:
            begin
                if (fsum > F_LIM)
                begin
                    filt_next = FILT_W'(PRESS_LIMIT);
                end
                else if (fsum < -F_LIM)
                begin
                    filt_next = -FILT_W'(PRESS_LIMIT);
                end
                else
                begin
                    filt_next = FILT_W'(fsum);
                end
                state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                qmul_next  = 31'(qval) * 31'(SPEED_SCALE);
                state_next = ST_SPD_DIV;
            end
            ST_SPD_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(qmul_reg) << (2 * SPEED_FRAC_BITS);
                div_divisor  = DIVISOR_W'(dens_eff) << PRESSURE_FRAC_BITS;
                state_next   = ST_SPD_WAIT;
            end
            ST_SPD_WAIT:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    speed_next = (vhalf > RW'(SPEED_MAX)) ? 16'(SPEED_MAX) : vhalf[15:0];
                    asv_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_acc_next     = acc_reg;
                    o_asv_next     = asv_reg;
                    o_rawp_next    = acc_reg ? rawp_reg : 14'd0;
                    o_rawt_next    = acc_reg ? rawt_reg : 11'd0;
                    o_temp_next    = acc_reg ? temp_reg : 17'sd0;
                    o_filt_next    = asv_reg ? filt_reg : 19'sd0;
                    o_speed_next   = asv_reg ? speed_reg : 16'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cfg_samples_reg <= CAL_SAMPLES_RST;
            cfg_alpha_reg   <= FILT_ALPHA_RST;
            cfg_db_reg      <= DEADBAND_RST;
            cfg_dens_reg    <= AIR_DENSITY_RST;
            cal_reg         <= 1'b0;
            count_reg       <= '0;
            sum_reg         <= '0;
            zero_reg        <= '0;
            seeded_reg      <= 1'b0;
            filt_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cfg_samples_reg <= cfg_samples_next;
            cfg_alpha_reg   <= cfg_alpha_next;
            cfg_db_reg      <= cfg_db_next;
            cfg_dens_reg    <= cfg_dens_next;
            cal_reg         <= cal_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            zero_reg        <= zero_next;
            seeded_reg      <= seeded_next;
            filt_reg        <= filt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        rawp_reg     <= rawp_next;
        rawt_reg     <= rawt_next;
        acc_reg      <= acc_next;
        asv_reg      <= asv_next;
        temp_reg     <= temp_next;
        pmul_reg     <= pmul_next;
        pneg_reg     <= pneg_next;
        press_reg    <= press_next;
        corr_reg     <= corr_next;
        fprod_reg    <= fprod_next;
        fneg_reg     <= fneg_next;
        qmul_reg     <= qmul_next;
        speed_reg    <= speed_next;
        o_status_reg <= o_status_next;
        o_acc_reg    <= o_acc_next;
        o_asv_reg    <= o_asv_next;
        o_rawp_reg   <= o_rawp_next;
        o_rawt_reg   <= o_rawt_next;
        o_temp_reg   <= o_temp_next;
        o_filt_reg   <= o_filt_next;
        o_speed_reg  <= o_speed_next;
    end

    pafp_div #(
        .DIV_W (DIV_W),
        .DVS_W (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    pafp_sqrt #(
        .SQ_W (SQ_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (SQ_W'(div_quo)),
        .done     (sqrt_done),
        .root     (sq_root)
    );

    assign in_ready          = state_reg == ST_IDLE;
    assign out_valid         = out_valid_reg;
    assign sensor_status     = o_status_reg;
    assign accepted          = o_acc_reg;
    assign airspeed_valid    = o_asv_reg;
    assign raw_pressure      = o_rawp_reg;
    assign raw_temperature   = o_rawt_reg;
    assign temperature       = o_temp_reg;
    assign filtered_pressure = o_filt_reg;
    assign airspeed          = o_speed_reg;

    assign in_div_wait  = (state_reg == ST_TEMP_WAIT) || (state_reg == ST_PRESS_WAIT)
                          || (state_reg == ST_ZERO_WAIT) || (state_reg == ST_SPD_WAIT);
    assign out_rejected = out_valid_reg && (o_status_reg != STATUS_NORMAL);

    `PAFP_ASSERT_IMP(a_speed_needs_word, out_valid_reg && o_asv_reg, o_acc_reg)
    `PAFP_ASSERT_IMP(a_reject_clears, out_rejected, !o_acc_reg && (o_rawp_reg == 14'd0))
    `PAFP_ASSERT_IMP(a_seed_after_cal, seeded_reg, cal_reg)
    `PAFP_ASSERT_IMP(a_div_done_waited, div_done, in_div_wait)
    `PAFP_ASSERT_NXT(a_zero_sets_cal, (state_reg == ST_ZERO_WAIT) && div_done, cal_reg)

endmodule

`default_nettype wire
